/* rtl/core/s2i_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_pkg
// Shared types and constants of the string to integer parser.
// ----------------------------------------------------------------------------
package s2i_pkg;

    typedef logic [5:0] t_base;
    typedef logic [7:0] t_char;

    localparam t_base BASE_AUTO = 6'd0;
    localparam t_base BASE_OCT  = 6'd8;
    localparam t_base BASE_DEC  = 6'd10;
    localparam t_base BASE_HEX  = 6'd16;
    localparam t_base BASE_MAX  = 6'd36;
    localparam t_base BASE_RESET = BASE_DEC;

    localparam logic [5:0] DIGIT_NONE = 6'd63;

    localparam t_char CH_SPACE   = 8'h20;
    localparam t_char CH_TAB     = 8'h09;
    localparam t_char CH_NEWLINE = 8'h0A;
    localparam t_char CH_PLUS    = 8'h2B;
    localparam t_char CH_MINUS   = 8'h2D;
    localparam t_char CH_ZERO    = 8'h30;
    localparam t_char CH_NINE    = 8'h39;
    localparam t_char CH_UPPER_A = 8'h41;
    localparam t_char CH_UPPER_X = 8'h58;
    localparam t_char CH_UPPER_Z = 8'h5A;
    localparam t_char CH_LOWER_A = 8'h61;
    localparam t_char CH_LOWER_X = 8'h78;
    localparam t_char CH_LOWER_Z = 8'h7A;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one classified character as it travels from front to back
    typedef struct packed {
        logic       eos;
        logic       is_ws;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic [5:0] digit;
    } t_cls;

endpackage

/* rtl/core/s2i_char_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_char_if
// Character channel: one ASCII byte and its end of string mark per transfer.
// ----------------------------------------------------------------------------
interface s2i_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_string;

    modport source (output valid, output char_byte, output end_of_string, input ready);
    modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

/* rtl/core/s2i_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_result_if
// Result channel: parsed value, consumed byte count and bad base flag.
// ----------------------------------------------------------------------------
interface s2i_result_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] parsed_value;
    logic        [7:0]  chars_consumed;
    logic               bad_base;

    modport source (output valid, output parsed_value, output chars_consumed,
                    output bad_base, input ready);
    modport sink   (input valid, input parsed_value, input chars_consumed,
                    input bad_base, output ready);
endinterface

/* rtl/core/s2i_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_front
// Accepts characters and classifies each one (whitespace, sign, prefix
// letters, digit value) before it enters the queue.
// ----------------------------------------------------------------------------
module s2i_front (
    s2i_char_if.sink    i_char,
    input  logic        i_full,
    output logic        o_push,
    output s2i_pkg::t_cls o_cls
);
    import s2i_pkg::*;

    t_char c;

    assign c            = i_char.char_byte;
    assign i_char.ready = !i_full;
    assign o_push       = i_char.valid && !i_full;

    always_comb begin
        o_cls          = '0;
        o_cls.eos      = i_char.end_of_string;
        o_cls.is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
        o_cls.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
        o_cls.is_minus = (c == CH_MINUS);
        o_cls.is_zero  = (c == CH_ZERO);
        o_cls.is_x     = (c == CH_LOWER_X) || (c == CH_UPPER_X);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            o_cls.digit = 6'(c - CH_ZERO);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            o_cls.digit = 6'(c - CH_LOWER_A + 8'd10);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            o_cls.digit = 6'(c - CH_UPPER_A + 8'd10);
        end else begin
            o_cls.digit = DIGIT_NONE;
        end
    end

endmodule

/* rtl/core/s2i_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module s2i_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  s2i_pkg::t_cls i_data,
    input  logic          i_pop,
    output s2i_pkg::t_cls o_data,
    output logic          o_full,
    output logic          o_empty
);
    import s2i_pkg::*;

    t_cls                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/core/s2i_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_back
// Parse state machine: base latch, sign, prefix, multiply-add accumulate,
// and the registered result stage.
// ----------------------------------------------------------------------------
module s2i_back #(
    parameter int MAX_LEN = 255
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  s2i_pkg::t_base i_base_select,
    input  s2i_pkg::t_cls  i_cls,
    input  logic           i_empty,
    output logic           o_pop,
    s2i_result_if.source   o_result
);
    import s2i_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        PH_WS,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    t_phase        r_phase,   n_phase;
    logic          r_neg,     n_neg;
    logic [63:0]   r_acc,     n_acc;
    logic [CW-1:0] r_cnt,     n_cnt;
    t_base         r_base,    n_base;

    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_out_acc,   n_out_acc;
    logic          r_out_neg,   n_out_neg;
    logic          r_out_bad,   n_out_bad;
    logic [7:0]    r_out_cnt,   n_out_cnt;

    logic          slot_free;
    logic          take_pre;
    logic          take_dig;
    logic          bump;
    logic          bad;
    t_base         pre_base;

    function automatic logic base_is_bad(t_base b);
        return (b == 6'd1) || (b > BASE_MAX);
    endfunction

    assign slot_free = !r_out_valid || o_result.ready;
    assign o_pop     = !i_empty && (!i_cls.eos || slot_free);

    assign o_result.valid          = r_out_valid;
    assign o_result.parsed_value   = r_out_neg ? -$signed(r_out_acc) : $signed(r_out_acc);
    assign o_result.chars_consumed = r_out_cnt;
    assign o_result.bad_base       = r_out_bad;

    always_comb begin
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_base      = r_base;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_acc   = r_out_acc;
        n_out_neg   = r_out_neg;
        n_out_bad   = r_out_bad;
        n_out_cnt   = r_out_cnt;
        take_pre    = 1'b0;
        take_dig    = 1'b0;
        bump        = 1'b0;
        bad         = 1'b0;
        pre_base    = r_base;

        if (o_pop) begin
            unique case (r_phase)
                PH_WS: begin
                    if (i_cls.is_ws) begin
                        bump = 1'b1;
                    end else begin
                        n_base   = i_base_select;
                        pre_base = i_base_select;
                        if (i_cls.is_sign) begin
                            n_neg   = i_cls.is_minus;
                            bump    = 1'b1;
                            n_phase = base_is_bad(i_base_select) ? PH_DONE : PH_PREFIX;
                        end else if (base_is_bad(i_base_select)) begin
                            n_phase = PH_DONE;
                        end else begin
                            take_pre = 1'b1;
                        end
                    end
                end
                PH_PREFIX: take_pre = 1'b1;
                PH_ZERO: begin
                    if (i_cls.is_x) begin
                        n_base  = BASE_HEX;
                        bump    = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        take_dig = 1'b1;
                    end
                end
                PH_DIGITS: take_dig = 1'b1;
                default:   n_phase = PH_DONE;
            endcase

            // optional leading zero, octal detect or hex prefix start
            if (take_pre) begin
                if (i_cls.is_zero && (pre_base == BASE_AUTO || pre_base == BASE_HEX)) begin
                    n_base  = (pre_base == BASE_AUTO) ? BASE_OCT : pre_base;
                    bump    = 1'b1;
                    n_phase = PH_ZERO;
                end else begin
                    n_base   = (pre_base == BASE_AUTO) ? BASE_DEC : pre_base;
                    take_dig = 1'b1;
                end
            end

            if (take_dig) begin
                if (i_cls.digit >= n_base) begin
                    n_phase = PH_DONE;
                end else begin
                    n_acc   = r_acc * 64'(n_base) + 64'(i_cls.digit);
                    bump    = 1'b1;
                    n_phase = PH_DIGITS;
                end
            end

            if (bump && r_cnt < CW'(MAX_LEN)) begin
                n_cnt = r_cnt + 1'b1;
            end

            if (i_cls.eos) begin
                bad         = base_is_bad((n_phase == PH_WS) ? i_base_select : n_base);
                n_out_valid = 1'b1;
                n_out_acc   = bad ? '0 : n_acc;
                n_out_neg   = n_neg && !bad;
                n_out_bad   = bad;
                n_out_cnt   = 8'(n_cnt);
                n_phase     = PH_WS;
                n_neg       = 1'b0;
                n_acc       = '0;
                n_cnt       = '0;
                n_base      = BASE_AUTO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WS;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_base      <= BASE_AUTO;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
        r_out_acc <= n_out_acc;
        r_out_neg <= n_out_neg;
        r_out_bad <= n_out_bad;
        r_out_cnt <= n_out_cnt;
    end

endmodule

/* rtl/core/string_to_integer_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser_top
// Streaming strtol-style parser: one ASCII byte per transfer in, one signed
// 64-bit result per string out.
// Throughput: one byte per cycle while no end of string byte waits on a
// stalled result; the accumulator multiply-add is combinational.
// Path: the end of string byte is written into the queue, popped by the
// back stage and registered into the result stage that drives valid.
// Reset: synchronous active low; clears queue, parse state and result valid,
// base_select returns to 10.
// ----------------------------------------------------------------------------
module string_to_integer_parser_top #(
    parameter int MAX_LEN = 255
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  s2i_pkg::t_base i_cfg_base_select,
    s2i_char_if.sink       i_char,
    s2i_result_if.source   o_result
);
    import s2i_pkg::*;

    t_base r_base_select;
    t_cls  front_cls;
    t_cls  queue_cls;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_select <= BASE_RESET;
        end else if (i_cfg_we) begin
            r_base_select <= i_cfg_base_select;
        end
    end

    s2i_front u_front (
        .i_char (i_char),
        .i_full (full),
        .o_push (push),
        .o_cls  (front_cls)
    );

    s2i_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .i_pop   (pop),
        .o_data  (queue_cls),
        .o_full  (full),
        .o_empty (empty)
    );

    s2i_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_base_select (r_base_select),
        .i_cls         (queue_cls),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_result      (o_result)
    );

endmodule

/* rtl/core/s2i_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module s2i_checker #(
    parameter int MAX_LEN = 255
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_eos,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_value,
    input logic [7:0]  i_out_count,
    input logic        i_out_bad
);

    logic [2:0] r_pending;
    logic       in_end;
    logic       out_xfer;

    assign in_end   = i_in_valid && i_in_ready && i_in_eos;
    assign out_xfer = i_out_valid && i_out_ready;

    // strings ended but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_end && !out_xfer) begin
            r_pending <= r_pending + 1'b1;
        end else if (!in_end && out_xfer) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_result_has_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 3'd0)
        else $error("result without an ended string");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_count) && $stable(i_out_bad))
        else $error("stalled result changed");

    a_bad_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad |-> i_out_value == 64'd0)
        else $error("bad base with nonzero value");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (MAX_LEN > 255) || (32'(i_out_count) <= 32'(MAX_LEN)))
        else $error("consumed count above limit");

endmodule

bind string_to_integer_parser_top s2i_checker #(
    .MAX_LEN (MAX_LEN)
) u_s2i_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_char.valid),
    .i_in_ready  (i_char.ready),
    .i_in_eos    (i_char.end_of_string),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_value (o_result.parsed_value),
    .i_out_count (o_result.chars_consumed),
    .i_out_bad   (o_result.bad_base)
);
